// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rasterizer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define RTD_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rtd assertion failed");

// next-cycle implication, off during reset
`define RTD_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rtd assertion failed");

`endif

// ===== hdl/rtd_pkg.sv =====
package rtd_pkg;

  // default render target limits
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  // field widths
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned PIX_W   = 10;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned DEPTH_W = 24;
  localparam int unsigned TEX_W   = 16;
  localparam int unsigned COLOR_W = 32;

  // setup arithmetic widths
  localparam int unsigned RECIP_W = 32;
  localparam int unsigned AREA_W  = 34;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned QUOT_W  = 31;
  localparam int unsigned EDGE_W  = 35;
  localparam int unsigned BARY_W  = 17;

  localparam logic [DEPTH_W-1:0] DEPTH_FAR      = '1;
  localparam logic [SIZE_W-1:0]  CFG_SIZE_RESET = 11'd1024;

  // queue depths
  localparam int unsigned JOB_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 2;

  typedef enum logic {ACT_VERTEX = 1'b0, ACT_PIXEL = 1'b1} action_e;
  typedef enum logic {KIND_SETUP = 1'b0, KIND_FRAG = 1'b1} kind_e;
  typedef enum logic {CFG_SCREEN_WIDTH = 1'b0, CFG_SCREEN_HEIGHT = 1'b1} cfg_idx_e;
  typedef enum logic [1:0] {SLOT_0, SLOT_1, SLOT_2, SLOT_NONE} slot_e;

  typedef enum logic [2:0] {F_IDLE, F_DET, F_NORM, F_DIV, F_REPORT} front_state_e;
  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_EDGE, B_COVER, B_BARY, B_ACC, B_FINAL, B_EMIT
  } back_state_e;

  typedef struct packed {
    action_e            action;
    slot_e              vertex_slot;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [DEPTH_W-1:0] vert_depth;
    logic [TEX_W-1:0]   tex_u;
    logic [TEX_W-1:0]   tex_v;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
  } item_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0]   x;
    logic [2:0][POS_W-1:0]   y;
    logic [2:0][DEPTH_W-1:0] z;
    logic [2:0][TEX_W-1:0]   u;
    logic [2:0][TEX_W-1:0]   v;
    logic [RECIP_W-1:0]      recip;
    logic [SHIFT_W-1:0]      shift;
    logic                    culled;
  } tri_t;

  typedef struct packed {
    logic [PIX_W-1:0] min_x;
    logic [PIX_W-1:0] min_y;
    logic [PIX_W-1:0] max_x;
    logic [PIX_W-1:0] max_y;
  } box_t;

  typedef struct packed {
    kind_e            kind;
    logic             culled;
    box_t             box;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
  } job_t;

  typedef struct packed {
    kind_e              kind;
    logic               culled;
    box_t               box;
    logic               covered;
    logic               depth_pass;
    logic [DEPTH_W-1:0] frag_depth;
    logic [COLOR_W-1:0] frag_color;
  } result_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } back_status_t;

endpackage

// ===== hdl/rtd_fifo.sv =====
module rtd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end
endmodule

// ===== hdl/rtd_front.sv =====
`include "assert_macros.svh"
module rtd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  rtd_pkg::item_t             item_i,
  output logic                       full_o,
  input  logic                       drained_i,
  input  logic [rtd_pkg::SIZE_W-1:0] width_i,
  input  logic [rtd_pkg::SIZE_W-1:0] height_i,
  output logic                       job_push_o,
  output rtd_pkg::job_t              job_o,
  input  logic                       job_full_i,
  output rtd_pkg::tri_t              tri_o
);
  import rtd_pkg::*;

  // floor of a Q12.4 coordinate, clamped to 0..size-1
  function automatic logic [PIX_W-1:0] box_coord(input logic [POS_W-1:0] q4,
                                                 input logic [SIZE_W-1:0] size);
    logic signed [SIZE_W+1:0] pe;
    logic signed [SIZE_W+1:0] lim;
    logic [SIZE_W+1:0]        res;
    pe  = {q4[POS_W-1], q4[POS_W-1:4]};
    lim = $signed({2'b00, size}) - 13'sd1;
    if (pe < 0) begin
      res = '0;
    end else if (pe > lim) begin
      res = lim;
    end else begin
      res = pe;
    end
    return res[PIX_W-1:0];
  endfunction

  front_state_e state_q, state_d;
  logic         hold_valid_q;
  item_t        hold_q;
  logic         consume, load_corner, set_culled;
  logic [1:0]   slot_idx;

  logic [2:0][POS_W-1:0]   cx_q, cy_q;
  logic [2:0][DEPTH_W-1:0] cz_q;
  logic [2:0][TEX_W-1:0]   cu_q, cv_q;
  logic [RECIP_W-1:0]      recip_q;
  logic [SHIFT_W-1:0]      shift_q;
  logic                    culled_q;

  logic [AREA_W-1:0]  area_q;
  logic [SHIFT_W-1:0] n_q;
  logic [AREA_W-1:0]  rem_q;
  logic [QUOT_W-1:0]  quot_q;
  logic [4:0]         cnt_q;

  logic signed [POS_W:0]     dx1, dy1, dx2, dy2;
  logic signed [2*POS_W+1:0] p0, p1;
  logic signed [2*POS_W+2:0] det;
  logic [2*POS_W+2:0]        area_full;
  logic [AREA_W:0]           trial;
  logic                      ge;
  logic [QUOT_W-1:0]         quot_nx;
  logic [AREA_W-1:0]         rem_init;
  logic signed [POS_W-1:0]   mn_x, mx_x, mn_y, mx_y;

  assign slot_idx = hold_q.vertex_slot;
  assign full_o   = hold_valid_q & ~consume;

  // determinant of the loaded corners
  always_comb begin
    dx1 = $signed({cx_q[1][POS_W-1], cx_q[1]}) - $signed({cx_q[0][POS_W-1], cx_q[0]});
    dy1 = $signed({cy_q[1][POS_W-1], cy_q[1]}) - $signed({cy_q[0][POS_W-1], cy_q[0]});
    dx2 = $signed({cx_q[2][POS_W-1], cx_q[2]}) - $signed({cx_q[0][POS_W-1], cx_q[0]});
    dy2 = $signed({cy_q[2][POS_W-1], cy_q[2]}) - $signed({cy_q[0][POS_W-1], cy_q[0]});
    p0  = dx1 * dy2;
    p1  = dy1 * dx2;
    det = {p0[2*POS_W+1], p0} - {p1[2*POS_W+1], p1};
    area_full = '0 - det;
  end

  // one restoring division step, ones shifted in from the numerator
  always_comb begin
    trial   = {rem_q, 1'b1};
    ge      = (trial >= {1'b0, area_q});
    quot_nx = {quot_q[QUOT_W-2:0], ge};
    if (n_q >= SHIFT_W'(2)) begin
      rem_init = (AREA_W'(1) << (n_q - SHIFT_W'(2))) - AREA_W'(1);
    end else begin
      rem_init = '0;
    end
  end

  // bounding box extremes
  always_comb begin
    mn_x = $signed(cx_q[0]);
    mx_x = $signed(cx_q[0]);
    mn_y = $signed(cy_q[0]);
    mx_y = $signed(cy_q[0]);
    for (int i = 1; i < 3; i++) begin
      if ($signed(cx_q[i]) < mn_x) mn_x = $signed(cx_q[i]);
      if ($signed(cx_q[i]) > mx_x) mx_x = $signed(cx_q[i]);
      if ($signed(cy_q[i]) < mn_y) mn_y = $signed(cy_q[i]);
      if ($signed(cy_q[i]) > mx_y) mx_y = $signed(cy_q[i]);
    end
  end

  // classify held item and sequence the setup
  always_comb begin
    state_d     = state_q;
    consume     = 1'b0;
    load_corner = 1'b0;
    set_culled  = 1'b0;
    job_push_o  = 1'b0;
    job_o       = '0;
    case (state_q)
      F_IDLE: begin
        if (hold_valid_q) begin
          if (hold_q.action == ACT_PIXEL) begin
            if (!job_full_i) begin
              consume    = 1'b1;
              job_push_o = 1'b1;
              job_o.kind = KIND_FRAG;
              job_o.px   = hold_q.pixel_x;
              job_o.py   = hold_q.pixel_y;
            end
          end else if (hold_q.vertex_slot == SLOT_NONE) begin
            consume = 1'b1;
          end else if (drained_i) begin
            consume     = 1'b1;
            load_corner = 1'b1;
            if (hold_q.vertex_slot == SLOT_2) begin
              state_d = F_DET;
            end else begin
              set_culled = 1'b1;
            end
          end
        end
      end
      F_DET: begin
        state_d = det[2*POS_W+2] ? F_NORM : F_REPORT;
      end
      F_NORM: begin
        if (area_q[n_q - SHIFT_W'(1)]) state_d = F_DIV;
      end
      F_DIV: begin
        if (cnt_q == 5'(QUOT_W - 1)) state_d = F_REPORT;
      end
      F_REPORT: begin
        if (!job_full_i) begin
          job_push_o       = 1'b1;
          job_o.kind       = KIND_SETUP;
          job_o.culled     = culled_q;
          job_o.box.min_x  = box_coord(mn_x, width_i);
          job_o.box.min_y  = box_coord(mn_y, height_i);
          job_o.box.max_x  = box_coord(mx_x, width_i);
          job_o.box.max_y  = box_coord(mx_y, height_i);
          state_d          = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      hold_valid_q <= 1'b0;
      culled_q     <= 1'b1;
      recip_q      <= '0;
      shift_q      <= '0;
    end else begin
      state_q <= state_d;
      if (push_i && !full_o) begin
        hold_valid_q <= 1'b1;
      end else if (consume) begin
        hold_valid_q <= 1'b0;
      end
      if (set_culled) begin
        culled_q <= 1'b1;
      end else if (state_q == F_DET && !det[2*POS_W+2]) begin
        culled_q <= 1'b1;
      end else if (state_q == F_DIV && cnt_q == 5'(QUOT_W - 1)) begin
        culled_q <= 1'b0;
        // a unit area has a dividend one bit shorter than the steps taken
        recip_q  <= (n_q == SHIFT_W'(1)) ? {2'b00, quot_nx[QUOT_W-1:1]} : {1'b0, quot_nx};
        shift_q  <= n_q;
      end
    end
  end

  // held item, corners and divider datapath
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      hold_q <= item_i;
    end
    if (load_corner) begin
      cx_q[slot_idx] <= hold_q.pos_x;
      cy_q[slot_idx] <= hold_q.pos_y;
      cz_q[slot_idx] <= hold_q.vert_depth;
      cu_q[slot_idx] <= hold_q.tex_u;
      cv_q[slot_idx] <= hold_q.tex_v;
    end
    case (state_q)
      F_DET: begin
        area_q <= area_full[AREA_W-1:0];
        n_q    <= SHIFT_W'(AREA_W);
      end
      F_NORM: begin
        if (area_q[n_q - SHIFT_W'(1)]) begin
          rem_q  <= rem_init;
          quot_q <= '0;
          cnt_q  <= '0;
        end else begin
          n_q <= n_q - SHIFT_W'(1);
        end
      end
      F_DIV: begin
        rem_q  <= ge ? AREA_W'(trial - {1'b0, area_q}) : trial[AREA_W-1:0];
        quot_q <= quot_nx;
        cnt_q  <= cnt_q + 5'd1;
      end
      default: ;
    endcase
  end

  assign tri_o.x      = cx_q;
  assign tri_o.y      = cy_q;
  assign tri_o.z      = cz_q;
  assign tri_o.u      = cu_q;
  assign tri_o.v      = cv_q;
  assign tri_o.recip  = recip_q;
  assign tri_o.shift  = shift_q;
  assign tri_o.culled = culled_q;

  // triangle state only changes with nothing in flight behind it
  `RTD_ASSERT_IMP(a_div_drained, clk_i, rst_ni, (state_q == F_DIV), drained_i)
  // a partial triangle load kills coverage
  `RTD_ASSERT_NXT(a_partial_culls, clk_i, rst_ni, (set_culled), culled_q)
endmodule

// ===== hdl/rtd_back.sv =====
`include "assert_macros.svh"
module rtd_back #(
  parameter int unsigned MAX_WIDTH  = rtd_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = rtd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_empty_i,
  output logic                       job_pop_o,
  input  rtd_pkg::job_t              job_i,
  input  rtd_pkg::tri_t              tri_i,
  input  logic [rtd_pkg::SIZE_W-1:0] width_i,
  input  logic [rtd_pkg::SIZE_W-1:0] height_i,
  output logic                       res_push_o,
  output rtd_pkg::result_t           res_o,
  input  logic                       res_full_i,
  output rtd_pkg::back_status_t      status_o
);
  import rtd_pkg::*;

  localparam int unsigned MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam logic [1:0]  LAST_CORNER = 2'd2;

  // corner that follows k around the triangle
  function automatic logic [1:0] next_corner(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Q.28 texture sum to an 8-bit channel with saturation
  function automatic logic [7:0] channel(input logic signed [35:0] s);
    logic [36:0] t;
    logic [7:0]  r;
    t = {1'b0, s[27:0], 8'h00} - {9'h000, s[27:0]} + 37'(1 << 27);
    if (s <= 0) begin
      r = 8'h00;
    end else if (s >= 36'sd268435456) begin
      r = 8'hFF;
    end else begin
      r = t[35:28];
    end
    return r;
  endfunction

  back_state_e state_q, state_d;
  logic [AW-1:0] clr_addr_q;

  logic [DEPTH_W-1:0] mem_q [MEM_DEPTH];
  logic [DEPTH_W-1:0] rd_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_wa, job_addr, addr_q;
  logic [DEPTH_W-1:0] mem_wd;

  logic [PIX_W-1:0]                px_q, py_q;
  logic [1:0]                      k_q, ia, ib;
  logic signed [EDGE_W-1:0]        e_q [3];
  logic [BARY_W-1:0]               b_q [3];
  logic [2*DEPTH_W-6:0]            acc_z_q;
  logic signed [35:0]              acc_u_q, acc_v_q;
  result_t                         res_q;

  logic                            live, any_neg, pass;
  logic signed [POS_W:0]           dcx, dcy, dby, dbx;
  logic signed [2*POS_W+1:0]       m0, m1;
  logic signed [EDGE_W-1:0]        edge_val;
  logic [AREA_W-1:0]               wn;
  logic [AREA_W+RECIP_W-1:0]       bprod;
  logic [DEPTH_W+BARY_W-1:0]       zprod;
  logic signed [TEX_W+BARY_W:0]    uprod, vprod;
  logic [2*DEPTH_W-5:0]            zsum;
  logic [DEPTH_W-1:0]              z;

  // pixel on screen and triangle live
  assign live = !tri_i.culled && ({1'b0, job_i.px} < width_i) && ({1'b0, job_i.py} < height_i);
  assign job_addr = AW'(job_i.py) * AW'(MAX_WIDTH) + AW'(job_i.px);

  // one edge function per step
  always_comb begin
    ia  = next_corner(k_q);
    ib  = next_corner(ia);
    dcx = $signed({3'b000, px_q, 4'h8}) - $signed({tri_i.x[ia][POS_W-1], tri_i.x[ia]});
    dcy = $signed({3'b000, py_q, 4'h8}) - $signed({tri_i.y[ia][POS_W-1], tri_i.y[ia]});
    dbx = $signed({tri_i.x[ib][POS_W-1], tri_i.x[ib]})
        - $signed({tri_i.x[ia][POS_W-1], tri_i.x[ia]});
    dby = $signed({tri_i.y[ib][POS_W-1], tri_i.y[ib]})
        - $signed({tri_i.y[ia][POS_W-1], tri_i.y[ia]});
    m0  = dcx * dby;
    m1  = dcy * dbx;
    edge_val = {m0[2*POS_W+1], m0} - {m1[2*POS_W+1], m1};
    any_neg  = e_q[0][EDGE_W-1] | e_q[1][EDGE_W-1] | e_q[2][EDGE_W-1];
  end

  // barycentric and weighted sums
  always_comb begin
    wn    = e_q[k_q][AREA_W-1:0] << (SHIFT_W'(AREA_W) - tri_i.shift);
    bprod = wn * tri_i.recip;
    zprod = tri_i.z[k_q] * b_q[k_q];
    uprod = $signed(tri_i.u[k_q]) * $signed({1'b0, b_q[k_q]});
    vprod = $signed(tri_i.v[k_q]) * $signed({1'b0, b_q[k_q]});
    zsum  = {1'b0, acc_z_q} + (2*DEPTH_W-4)'(1 << 15);
    z     = (zsum[2*DEPTH_W-5:16] > {4'h0, DEPTH_FAR}) ? DEPTH_FAR : zsum[DEPTH_W+15:16];
    pass  = (z < rd_q);
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wa     = clr_addr_q;
    mem_wd     = DEPTH_FAR;
    case (state_q)
      B_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr_q == AW'(MEM_DEPTH - 1)) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          if (job_i.kind == KIND_FRAG && live) begin
            mem_re  = 1'b1;
            state_d = B_EDGE;
          end else begin
            state_d = B_EMIT;
          end
        end
      end
      B_EDGE:  if (k_q == LAST_CORNER) state_d = B_COVER;
      B_COVER: state_d = any_neg ? B_EMIT : B_BARY;
      B_BARY:  if (k_q == LAST_CORNER) state_d = B_ACC;
      B_ACC:   if (k_q == LAST_CORNER) state_d = B_FINAL;
      B_FINAL: begin
        mem_we  = pass;
        mem_wa  = addr_q;
        mem_wd  = z;
        state_d = B_EMIT;
      end
      B_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // depth memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem_q[job_addr];
  end

  // fragment datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        px_q   <= job_i.px;
        py_q   <= job_i.py;
        addr_q <= job_addr;
        k_q    <= '0;
        res_q  <= '{kind: job_i.kind, culled: job_i.culled, box: job_i.box,
                   covered: 1'b0, depth_pass: 1'b0, frag_depth: '0, frag_color: '0};
      end
      B_EDGE: begin
        e_q[k_q] <= edge_val;
        k_q      <= (k_q == LAST_CORNER) ? 2'd0 : k_q + 2'd1;
      end
      B_COVER: begin
        acc_z_q <= '0;
        acc_u_q <= '0;
        acc_v_q <= '0;
      end
      B_BARY: begin
        b_q[k_q] <= bprod[AREA_W+RECIP_W-3:47];
        k_q      <= (k_q == LAST_CORNER) ? 2'd0 : k_q + 2'd1;
      end
      B_ACC: begin
        acc_z_q <= acc_z_q + (2*DEPTH_W-5)'(zprod);
        acc_u_q <= acc_u_q + 36'(uprod);
        acc_v_q <= acc_v_q + 36'(vprod);
        k_q     <= (k_q == LAST_CORNER) ? 2'd0 : k_q + 2'd1;
      end
      B_FINAL: begin
        res_q.covered    <= 1'b1;
        res_q.frag_depth <= z;
        if (pass) begin
          res_q.depth_pass <= 1'b1;
          res_q.frag_color <= {8'hFF, 8'h00, channel(acc_v_q), channel(acc_u_q)};
        end
      end
      default: ;
    endcase
  end

  assign res_o             = res_q;
  assign status_o.clearing = (state_q == B_CLEAR);
  assign status_o.idle     = (state_q == B_IDLE);

  // the clearing pass runs once after reset
  `RTD_ASSERT_NXT(a_clear_once, clk_i, rst_ni, (state_q != B_CLEAR), (state_q != B_CLEAR))
  // a depth write only ever comes with coverage
  `RTD_ASSERT_IMP(a_pass_covered, clk_i, rst_ni, (res_push_o && res_o.depth_pass), res_o.covered)
endmodule

// ===== hdl/triangle_raster_depth_test.sv =====
// channel   direction  handshake              payload
// input     in         push / full            action .. pixel_y
// result    out        pop / empty            kind .. frag_color
// config    in         cfg_we_i               cfg_index_i, cfg_wdata_i
//
// in the back sequencer a covered pixel runs edge, cover, bary, acc and final; an uncovered
// one ends after cover and an off-screen one skips to emit; the front unit sets a triangle up
// by normalizing and then dividing; vertex loads wait until every earlier pixel test has left
// the back part; after reset the depth memory is cleared word by word, full held high; full
// rises while the held item waits: job queue full, vertex load or setup in progress
module triangle_raster_depth_test #(
  parameter int unsigned MAX_WIDTH  = rtd_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = rtd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [rtd_pkg::SIZE_W-1:0]  cfg_wdata_i,
  input  logic                        push,
  output logic                        full,
  input  logic                        action_i,
  input  logic [1:0]                  vertex_slot_i,
  input  logic [15:0]                 pos_x_i,
  input  logic [15:0]                 pos_y_i,
  input  logic [23:0]                 vert_depth_i,
  input  logic [15:0]                 tex_u_i,
  input  logic [15:0]                 tex_v_i,
  input  logic [9:0]                  pixel_x_i,
  input  logic [9:0]                  pixel_y_i,
  output logic                        empty,
  input  logic                        pop,
  output logic                        kind_o,
  output logic                        culled_o,
  output logic [9:0]                  box_min_x_o,
  output logic [9:0]                  box_min_y_o,
  output logic [9:0]                  box_max_x_o,
  output logic [9:0]                  box_max_y_o,
  output logic                        covered_o,
  output logic                        depth_pass_o,
  output logic [23:0]                 frag_depth_o,
  output logic [31:0]                 frag_color_o
);
  import rtd_pkg::*;

  logic [SIZE_W-1:0] width_q, height_q, eff_w, eff_h;
  item_t             item;
  tri_t              tri_st;
  job_t              job_in, job_out;
  result_t           res_in, res_out;
  back_status_t      status;
  logic              front_full, job_push, job_full, job_pop, job_empty;
  logic              res_push, res_full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_SIZE_RESET;
      height_q <= CFG_SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_SCREEN_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective screen size
  always_comb begin
    if (width_q == '0) begin
      eff_w = SIZE_W'(1);
    end else if ({2'b00, width_q} > 13'(MAX_WIDTH)) begin
      eff_w = SIZE_W'(MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    if (height_q == '0) begin
      eff_h = SIZE_W'(1);
    end else if ({2'b00, height_q} > 13'(MAX_HEIGHT)) begin
      eff_h = SIZE_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_q;
    end
  end

  assign item.action      = action_e'(action_i);
  assign item.vertex_slot = slot_e'(vertex_slot_i);
  assign item.pos_x       = pos_x_i;
  assign item.pos_y       = pos_y_i;
  assign item.vert_depth  = vert_depth_i;
  assign item.tex_u       = tex_u_i;
  assign item.tex_v       = tex_v_i;
  assign item.pixel_x     = pixel_x_i;
  assign item.pixel_y     = pixel_y_i;

  assign full = front_full | status.clearing;

  rtd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push & ~status.clearing),
    .item_i     (item),
    .full_o     (front_full),
    .drained_i  (job_empty & status.idle),
    .width_i    (eff_w),
    .height_i   (eff_h),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full),
    .tri_o      (tri_st)
  );

  // job queue between classification and pixel work
  rtd_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  rtd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .job_i       (job_out),
    .tri_i       (tri_st),
    .width_i     (eff_w),
    .height_i    (eff_h),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full),
    .status_o    (status)
  );

  // result queue facing the consumer
  rtd_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign kind_o       = res_out.kind;
  assign culled_o     = res_out.culled;
  assign box_min_x_o  = res_out.box.min_x;
  assign box_min_y_o  = res_out.box.min_y;
  assign box_max_x_o  = res_out.box.max_x;
  assign box_max_y_o  = res_out.box.max_y;
  assign covered_o    = res_out.covered;
  assign depth_pass_o = res_out.depth_pass;
  assign frag_depth_o = res_out.frag_depth;
  assign frag_color_o = res_out.frag_color;
endmodule

// ===== bench/triangle_raster_depth_checker.sv =====
`timescale 1ns / 100ps

module triangle_raster_depth_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        push,
  input  logic        full,
  input  logic        action_i,
  input  logic [1:0]  vertex_slot_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [23:0] vert_depth_i,
  input  logic [15:0] tex_u_i,
  input  logic [15:0] tex_v_i,
  input  logic [9:0]  pixel_x_i,
  input  logic [9:0]  pixel_y_i,
  input  logic        empty,
  input  logic        pop,
  input  logic        kind_o,
  input  logic        culled_o,
  input  logic [9:0]  box_min_x_o,
  input  logic [9:0]  box_min_y_o,
  input  logic [9:0]  box_max_x_o,
  input  logic [9:0]  box_max_y_o,
  input  logic        covered_o,
  input  logic        depth_pass_o,
  input  logic [23:0] frag_depth_o,
  input  logic [31:0] frag_color_o,
  output int          fail_count,
  output int          pending
);
  import rtd_pkg::*;

  localparam int unsigned ZBUF_SIZE = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

  // shadow copy of the rasterizer state
  logic signed [15:0] vx [3];
  logic signed [15:0] vy [3];
  logic signed [15:0] vu [3];
  logic signed [15:0] vv [3];
  logic [23:0]        vz [3];
  logic [31:0]        recip;
  int unsigned        recip_shift;
  bit                 tri_dead;
  logic [23:0]        zbuf [ZBUF_SIZE];
  logic [10:0]        width_reg;
  logic [10:0]        height_reg;

  result_t expected_q [$];

  assign pending = expected_q.size();

  initial begin
    fail_count = 0;
    recip = '0;
    recip_shift = 0;
    tri_dead = 1'b1;
    width_reg = CFG_SIZE_RESET;
    height_reg = CFG_SIZE_RESET;
    for (int i = 0; i < 3; i++) begin
      vx[i] = '0; vy[i] = '0; vu[i] = '0; vv[i] = '0; vz[i] = '0;
    end
    for (int i = 0; i < ZBUF_SIZE; i++) zbuf[i] = DEPTH_FAR;
  end

  function automatic int unsigned active_size(logic [10:0] r, int unsigned lim);
    if (r == 0) return 1;
    if (r > lim) return lim;
    return r;
  endfunction

  // floor to pixel, then clamp into the screen
  function automatic logic [9:0] box_edge(int q4, int unsigned size);
    int p;
    p = q4 >>> 4;
    if (p < 0) return '0;
    if (p > int'(size) - 1) return 10'(size - 1);
    return 10'(p);
  endfunction

  function automatic longint edge_value(longint ax, longint ay, longint bx, longint by,
                                        longint px, longint py);
    return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
  endfunction

  function automatic longint unsigned bary_weight(longint w);
    longint unsigned wn;
    wn = longint'(unsigned'(w)) << (34 - recip_shift);
    return (wn * longint'(recip)) >> 47;
  endfunction

  function automatic logic [7:0] color_channel(logic signed [15:0] t [3],
                                               longint unsigned b [3]);
    longint s;
    s = longint'(t[0]) * longint'(b[0]) + longint'(t[1]) * longint'(b[1])
      + longint'(t[2]) * longint'(b[2]);
    if (s <= 0) return 8'd0;
    if (s >= (longint'(1) << 28)) return 8'd255;
    return 8'((longint'(s) * 255 + (longint'(1) << 27)) >>> 28);
  endfunction

  // advance the shadow state by one transfer and queue its result, if it has one
  task automatic rasterize_item();
    result_t r;
    int unsigned w, h, n, slot, addr;
    longint det, area, cx, cy, e0, e1, e2, mnx, mny, mxx, mxy;
    longint unsigned b [3];
    longint unsigned zs;
    logic [23:0] z;
    r = '0;
    w = active_size(width_reg, DEF_MAX_WIDTH);
    h = active_size(height_reg, DEF_MAX_HEIGHT);
    if (action_e'(action_i) == ACT_VERTEX) begin
      slot = vertex_slot_i;
      if (slot_e'(vertex_slot_i) == SLOT_NONE) return;
      vx[slot] = pos_x_i; vy[slot] = pos_y_i; vz[slot] = vert_depth_i;
      vu[slot] = tex_u_i; vv[slot] = tex_v_i;
      if (slot_e'(vertex_slot_i) != SLOT_2) begin
        tri_dead = 1'b1;
        return;
      end
      det = (longint'(vx[1]) - vx[0]) * (longint'(vy[2]) - vy[0])
          - (longint'(vy[1]) - vy[0]) * (longint'(vx[2]) - vx[0]);
      if (det >= 0) begin
        tri_dead = 1'b1;
      end else begin
        area = -det;
        n = 0;
        while (n < 40 && (area >> n) != 0) n++;
        recip_shift = n;
        recip = 32'(((longint'(1) << (n + 29)) - 1) / area);
        tri_dead = 1'b0;
      end
      mnx = vx[0]; mxx = vx[0]; mny = vy[0]; mxy = vy[0];
      for (int i = 1; i < 3; i++) begin
        if (vx[i] < mnx) mnx = vx[i];
        if (vx[i] > mxx) mxx = vx[i];
        if (vy[i] < mny) mny = vy[i];
        if (vy[i] > mxy) mxy = vy[i];
      end
      r.kind = KIND_SETUP;
      r.culled = tri_dead;
      r.box.min_x = box_edge(int'(mnx), w);
      r.box.min_y = box_edge(int'(mny), h);
      r.box.max_x = box_edge(int'(mxx), w);
      r.box.max_y = box_edge(int'(mxy), h);
      expected_q.push_back(r);
      return;
    end
    r.kind = KIND_FRAG;
    if (!tri_dead && pixel_x_i < w && pixel_y_i < h) begin
      cx = longint'(pixel_x_i) * 16 + 8;
      cy = longint'(pixel_y_i) * 16 + 8;
      e0 = edge_value(vx[1], vy[1], vx[2], vy[2], cx, cy);
      e1 = edge_value(vx[2], vy[2], vx[0], vy[0], cx, cy);
      e2 = edge_value(vx[0], vy[0], vx[1], vy[1], cx, cy);
      if (e0 >= 0 && e1 >= 0 && e2 >= 0) begin
        b[0] = bary_weight(e0); b[1] = bary_weight(e1); b[2] = bary_weight(e2);
        zs = longint'(vz[0]) * b[0] + longint'(vz[1]) * b[1] + longint'(vz[2]) * b[2];
        zs = (zs + 32768) >> 16;
        z = (zs > DEPTH_FAR) ? DEPTH_FAR : 24'(zs);
        r.covered = 1'b1;
        r.frag_depth = z;
        addr = int'(pixel_y_i) * DEF_MAX_WIDTH + int'(pixel_x_i);
        if (z < zbuf[addr]) begin
          zbuf[addr] = z;
          r.depth_pass = 1'b1;
          r.frag_color = {8'hFF, 8'h00, color_channel(vv, b), color_channel(vu, b)};
        end
      end
    end
    expected_q.push_back(r);
  endtask

  function automatic bit field_ok(string name, logic [31:0] exp, logic [31:0] act);
    if (act !== exp) begin
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp, act);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // watch config writes, input transfers and result transfers
  always @(posedge clk_i) begin
    result_t e;
    bit ok;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_e'(cfg_index_i) == CFG_SCREEN_WIDTH) width_reg = cfg_wdata_i;
        else height_reg = cfg_wdata_i;
      end
      if (push && !full) rasterize_item();
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, kind %b", $time, kind_o);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          ok = 1'b1;
          ok &= field_ok("kind", e.kind, kind_o);
          ok &= field_ok("culled", e.culled, culled_o);
          ok &= field_ok("box_min_x", e.box.min_x, box_min_x_o);
          ok &= field_ok("box_min_y", e.box.min_y, box_min_y_o);
          ok &= field_ok("box_max_x", e.box.max_x, box_max_x_o);
          ok &= field_ok("box_max_y", e.box.max_y, box_max_y_o);
          ok &= field_ok("covered", e.covered, covered_o);
          ok &= field_ok("depth_pass", e.depth_pass, depth_pass_o);
          ok &= field_ok("frag_depth", e.frag_depth, frag_depth_o);
          ok &= field_ok("frag_color", e.frag_color, frag_color_o);
          if (!ok) fail_count++;
        end
      end
    end
  end

endmodule

// ===== bench/triangle_raster_depth_test_test.sv =====
`timescale 1ns / 100ps

module triangle_raster_depth_test_test;
  import rtd_pkg::*;

  localparam int IDLE_LIMIT = 3_500_000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [10:0] cfg_wdata_i;
  logic        push;
  logic        full;
  logic        action_i;
  logic [1:0]  vertex_slot_i;
  logic [15:0] pos_x_i;
  logic [15:0] pos_y_i;
  logic [23:0] vert_depth_i;
  logic [15:0] tex_u_i;
  logic [15:0] tex_v_i;
  logic [9:0]  pixel_x_i;
  logic [9:0]  pixel_y_i;
  logic        empty;
  logic        pop;
  logic        kind_o;
  logic        culled_o;
  logic [9:0]  box_min_x_o;
  logic [9:0]  box_min_y_o;
  logic [9:0]  box_max_x_o;
  logic [9:0]  box_max_y_o;
  logic        covered_o;
  logic        depth_pass_o;
  logic [23:0] frag_depth_o;
  logic [31:0] frag_color_o;
  int          fail_count;
  int          pending;
  int          sent_items;
  int          idle_cycles;

  triangle_raster_depth_test DUT (.*);

  triangle_raster_depth_checker u_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // no transfer on either side for too long ends the run
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // offer one item, optionally after a random gap, and wait for its transfer
  task automatic send_item(action_e act, slot_e slot, logic [15:0] x, logic [15:0] y,
                           logic [23:0] z, logic [15:0] u, logic [15:0] v,
                           logic [9:0] px, logic [9:0] py);
    int gap;
    gap = (sent_items % 120 < 25) ? 0 : $urandom_range(15);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    action_i <= act; vertex_slot_i <= slot;
    pos_x_i <= x; pos_y_i <= y; vert_depth_i <= z;
    tex_u_i <= u; tex_v_i <= v; pixel_x_i <= px; pixel_y_i <= py;
    do @(posedge clk_i); while (full);
    sent_items++;
  endtask

  task automatic send_vertex(slot_e slot, logic [15:0] x, logic [15:0] y, logic [23:0] z,
                             logic [15:0] u, logic [15:0] v);
    send_item(ACT_VERTEX, slot, x, y, z, u, v, 10'($urandom), 10'($urandom));
  endtask

  task automatic send_pixel(int px, int py);
    send_item(ACT_PIXEL, slot_e'($urandom_range(3)), 16'($urandom), 16'($urandom),
              24'($urandom), 16'($urandom), 16'($urandom), 10'(px), 10'(py));
  endtask

  // drain, let trailing vertex loads settle, then set the screen size
  task automatic set_screen(logic [10:0] w, logic [10:0] h);
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (150) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= CFG_SCREEN_WIDTH; cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_index_i <= CFG_SCREEN_HEIGHT; cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int to_pixel(int q4);
    int p;
    p = q4 >>> 4;
    return (p < 0) ? 0 : (p > 1023) ? 1023 : p;
  endfunction

  function automatic logic [23:0] pick_depth();
    case ($urandom_range(7))
      0: return '0;
      1: return DEPTH_FAR;
      default: return 24'($urandom);
    endcase
  endfunction

  // one front-facing (mostly) triangle followed by pixels around it
  task automatic random_triangle();
    int x [3];
    int y [3];
    int bx, by, t, npix, lx, hx, ly, hy;
    longint det;
    bit wild;
    wild = ($urandom_range(9) == 0);
    bx = $urandom_range(16376);
    by = $urandom_range(16376);
    for (int i = 0; i < 3; i++) begin
      if (wild) begin
        x[i] = $signed(16'($urandom));
        y[i] = $signed(16'($urandom));
      end else begin
        x[i] = bx + $urandom_range(480) - 240;
        y[i] = by + $urandom_range(480) - 240;
      end
    end
    det = longint'(x[1] - x[0]) * (y[2] - y[0]) - longint'(y[1] - y[0]) * (x[2] - x[0]);
    if (det >= 0 && $urandom_range(9) != 0) begin
      t = x[1]; x[1] = x[2]; x[2] = t;
      t = y[1]; y[1] = y[2]; y[2] = t;
    end
    for (int i = 0; i < 3; i++)
      send_vertex(slot_e'(i), 16'(x[i]), 16'(y[i]), pick_depth(),
                  16'($urandom), 16'($urandom));
    lx = to_pixel(x[0]); hx = lx; ly = to_pixel(y[0]); hy = ly;
    for (int i = 1; i < 3; i++) begin
      if (to_pixel(x[i]) < lx) lx = to_pixel(x[i]);
      if (to_pixel(x[i]) > hx) hx = to_pixel(x[i]);
      if (to_pixel(y[i]) < ly) ly = to_pixel(y[i]);
      if (to_pixel(y[i]) > hy) hy = to_pixel(y[i]);
    end
    npix = $urandom_range(12, 1);
    for (int k = 0; k < npix; k++) begin
      if ($urandom_range(7) == 0) send_pixel($urandom_range(1023), $urandom_range(1023));
      else send_pixel($urandom_range(hx, lx), $urandom_range(hy, ly));
    end
    // occasional noise: ignored slot or a lone corner reload that kills the triangle
    case ($urandom_range(9))
      0: send_vertex(SLOT_NONE, 16'($urandom), 16'($urandom), 24'($urandom),
                     16'($urandom), 16'($urandom));
      1: begin
        send_vertex(slot_e'($urandom_range(1)), 16'($urandom), 16'($urandom),
                    24'($urandom), 16'($urandom), 16'($urandom));
        send_pixel($urandom_range(hx, lx), $urandom_range(hy, ly));
      end
      default: ;
    endcase
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    int stall, pops;
    pop <= 1'b0;
    pops = 0;
    @(posedge rst_ni);
    forever begin
      if (pops == 300) stall = 600;
      else stall = (pops % 150 < 30) ? 0 : $urandom_range(15);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      pops++;
    end
  end

  // stimulus and verdict
  initial begin
    logic [10:0] widths [5];
    logic [10:0] heights [5];
    widths = '{11'd1024, 11'd2047, 11'd1, 11'd300, 11'd1024};
    heights = '{11'd1024, 11'd0, 11'd1024, 11'd700, 11'd1024};
    sent_items = 0;
    idle_cycles = 0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0; cfg_index_i <= CFG_SCREEN_WIDTH; cfg_wdata_i <= '0;
    push <= 1'b0;
    action_i <= ACT_VERTEX; vertex_slot_i <= SLOT_0;
    pos_x_i <= '0; pos_y_i <= '0; vert_depth_i <= '0;
    tex_u_i <= '0; tex_v_i <= '0; pixel_x_i <= '0; pixel_y_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // small front-facing triangle with saturating texture corners
    send_vertex(SLOT_0, 16'sd0, 16'sd0, 24'd0, 16'h7FFF, 16'h8000);
    send_vertex(SLOT_1, 16'sd0, 16'sd160, DEPTH_FAR, 16'h8000, 16'h7FFF);
    send_vertex(SLOT_2, 16'sd160, 16'sd0, 24'h800000, 16'h1000, 16'h0000);
    send_pixel(1, 1);
    send_pixel(1, 1);
    send_pixel(0, 0);
    send_pixel(4, 4);
    send_pixel(9, 9);
    // whole coordinate range, box clamped on both sides
    send_vertex(SLOT_0, 16'h8000, 16'h8000, DEPTH_FAR, 16'h0000, 16'hFFFF);
    send_vertex(SLOT_1, 16'h8000, 16'h7FFF, 24'd0, 16'h7FFF, 16'h0001);
    send_vertex(SLOT_2, 16'h7FFF, 16'h8000, 24'h000001, 16'hFFFF, 16'h7FFF);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(1023, 0);
    // back-facing triangle still reports its box, pixels uncovered
    send_vertex(SLOT_1, 16'sd160, 16'sd0, 24'd5, 16'd0, 16'd0);
    send_vertex(SLOT_2, 16'sd0, 16'sd160, 24'd5, 16'd0, 16'd0);
    send_pixel(2, 2);
    // zero-area triangle
    send_vertex(SLOT_0, 16'sd32, 16'sd32, 24'd5, 16'd0, 16'd0);
    send_vertex(SLOT_1, 16'sd64, 16'sd64, 24'd5, 16'd0, 16'd0);
    send_vertex(SLOT_2, 16'sd96, 16'sd96, 24'd5, 16'd0, 16'd0);
    send_pixel(3, 3);
    // ignored slot, then a lone reload that culls
    send_vertex(SLOT_NONE, 16'hFFFF, 16'hFFFF, DEPTH_FAR, 16'hFFFF, 16'hFFFF);
    send_vertex(SLOT_2, 16'sd0, 16'sd0, 24'd100, 16'd0, 16'd0);
    send_pixel(4, 5);
    send_vertex(SLOT_0, 16'sd0, 16'sd0, 24'd100, 16'd0, 16'd0);
    send_pixel(4, 5);

    for (int ph = 0; ph < 5; ph++) begin
      set_screen(widths[ph], heights[ph]);
      while (sent_items < 25 + (ph + 1) * 250) random_triangle();
    end

    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
